FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the k-mer counter RTL.
// Both macros expect signals named clk and rst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SSKIC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SSKIC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/sskic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sskic_pkg
// Shared constants, base code table and types of the spaced-seed counter.
// ----------------------------------------------------------------------------
package sskic_pkg;

    localparam int HASH_BITS_DEF = 16;
    localparam int MAX_SEED_DEF  = 32;
    localparam int QUEUE_DEPTH   = 4;
    localparam int PADDR_W       = 3;

    // register indexes (paddr[2])
    localparam logic REG_SEED_PATTERN = 1'b0;
    localparam logic REG_SEED_LENGTH  = 1'b1;

    localparam logic [31:0] PATTERN_RESET = 32'hFFFF_FFFF;
    localparam logic [5:0]  LENGTH_RESET  = 6'd32;

    localparam logic [7:0] CAP_LIMIT  = 8'd200;
    localparam logic [7:0] CAP_PARKED = 8'd201;

    localparam logic [2:0] CODE_OTHER = 3'd4;
    localparam logic [6:0] CHAR_N     = 7'h4E;

    // code by low five bits of an upper-half ASCII character
    localparam logic [2:0] BASE_CODE [32] = '{
        3'd4, 3'd0, 3'd4, 3'd1, 3'd4, 3'd4, 3'd4, 3'd2,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd4,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
    };

    typedef struct packed {
        logic [31:0] start;
        logic        hit;
    } sskic_win_t;

    function automatic logic [2:0] code_of(input logic [6:0] c);
        logic [2:0] r;
        if (!c[6])
            r = CODE_OTHER;
        else
            r = BASE_CODE[c[4:0]];
        return r;
    endfunction

endpackage

FILE: rtl/core/sskic_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sskic_in_if
// Character stream channel: one sequence character per item.
// ----------------------------------------------------------------------------
interface sskic_in_if;
    logic       valid;
    logic       ready;
    logic [6:0] base_char;
    logic       is_last;

    modport source (output valid, output base_char, output is_last, input ready);
    modport sink   (input valid, input base_char, input is_last, output ready);
endinterface

FILE: rtl/core/sskic_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sskic_out_if
// Result channel: one hash / count report per character item.
// ----------------------------------------------------------------------------
interface sskic_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] window_start;
    logic [15:0] kmer_hash;
    logic        hash_valid;
    logic        hash_stored;
    logic        first_seen;
    logic [31:0] valid_total;
    logic [31:0] distinct_total;

    modport source (
        output valid, output window_start, output kmer_hash, output hash_valid,
        output hash_stored, output first_seen, output valid_total,
        output distinct_total, input ready
    );
    modport sink (
        input valid, input window_start, input kmer_hash, input hash_valid,
        input hash_stored, input first_seen, input valid_total,
        input distinct_total, output ready
    );
endinterface

FILE: rtl/core/sskic_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sskic_cfg
// APB register file plus registered seed decode (lane select, shift, length).
// ----------------------------------------------------------------------------
module sskic_cfg #(
    parameter int MAX_SEED = sskic_pkg::MAX_SEED_DEF,
    parameter int LEN_W    = $clog2(MAX_SEED + 1),
    parameter int SH_W     = $clog2(2 * MAX_SEED)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sskic_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output logic [MAX_SEED-1:0]                sel_mask,
    output logic [MAX_SEED-1:0][SH_W-1:0]      shift_amt,
    output logic [LEN_W-1:0]                   seed_len,
    output logic                               settling
);
    import sskic_pkg::*;

    localparam logic [5:0] MAX_LEN6 = 6'(MAX_SEED);

    logic [31:0]                   pattern_reg;
    logic [5:0]                    length_reg;
    logic [MAX_SEED-1:0]           mask_reg,  mask_next;
    logic [MAX_SEED-1:0][SH_W-1:0] shift_reg, shift_next;
    logic [LEN_W-1:0]              len_reg,   len_next;
    logic                          settle_reg;
    logic                          wr;
    logic                          idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[2];

    always_comb
    begin
        unique case (idx)
            REG_SEED_PATTERN: prdata = pattern_reg;
            REG_SEED_LENGTH:  prdata = {26'd0, length_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= PATTERN_RESET;
            length_reg  <= LENGTH_RESET;
            settle_reg  <= 1'b1;
        end
        else
        begin
            settle_reg <= wr;
            if (wr)
            begin
                unique case (idx)
                    REG_SEED_PATTERN: pattern_reg <= pwdata;
                    REG_SEED_LENGTH:  length_reg  <= pwdata[5:0];
                    default:          pattern_reg <= pattern_reg;
                endcase
            end
        end
    end

    // Window entry b holds the base L-1-b from the start; its 2-bit slot in the
    // hash sits above one slot per selected entry below it.
    always_comb
    begin
        if (length_reg == 6'd0)
            len_next = LEN_W'(1);
        else if (length_reg > MAX_LEN6)
            len_next = LEN_W'(MAX_SEED);
        else
            len_next = LEN_W'(length_reg);
        for (int b = 0; b < MAX_SEED; b++)
        begin
            mask_next[b]  = pattern_reg[b] && (LEN_W'(b) < len_next);
            shift_next[b] = SH_W'(2 * $countones(pattern_reg & ((32'd1 << b) - 32'd1)));
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg  <= mask_next;
        shift_reg <= shift_next;
        len_reg   <= len_next;
    end

    assign sel_mask  = mask_reg;
    assign shift_amt = shift_reg;
    assign seed_len  = len_reg;
    assign settling  = settle_reg;

endmodule

FILE: rtl/core/sskic_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sskic_front
// Accepts characters, keeps the code window and position, forms the hash.
// ----------------------------------------------------------------------------
module sskic_front #(
    parameter int HASH_BITS = sskic_pkg::HASH_BITS_DEF,
    parameter int MAX_SEED  = sskic_pkg::MAX_SEED_DEF,
    parameter int LEN_W     = $clog2(MAX_SEED + 1),
    parameter int SH_W      = $clog2(2 * MAX_SEED)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sskic_in_if.sink                      bases,
    input  logic [MAX_SEED-1:0]           sel_mask,
    input  logic [MAX_SEED-1:0][SH_W-1:0] shift_amt,
    input  logic [LEN_W-1:0]              seed_len,
    input  logic                          settling,
    input  logic                          clearing,
    input  logic                          q_full,
    output logic                          push,
    output sskic_pkg::sskic_win_t         push_win,
    output logic [HASH_BITS-1:0]          push_hash
);
    import sskic_pkg::*;

    localparam int IDX_W = (MAX_SEED > 1) ? $clog2(MAX_SEED) : 1;

    logic [2:0]           code_reg  [MAX_SEED];
    logic [2:0]           code_next [MAX_SEED];
    logic                 isn_reg   [MAX_SEED];
    logic                 isn_next  [MAX_SEED];
    logic [31:0]          pos_reg, pos_next;
    logic [HASH_BITS-1:0] hash;
    logic [IDX_W-1:0]     first_idx;
    logic                 hit;
    logic                 accept;

    assign bases.ready = !settling && !clearing && !q_full;
    assign accept      = bases.valid && bases.ready;

    always_comb
    begin
        code_next[0] = code_of(bases.base_char);
        isn_next[0]  = (bases.base_char == CHAR_N);
        for (int k = 1; k < MAX_SEED; k++)
        begin
            code_next[k] = code_reg[k-1];
            isn_next[k]  = isn_reg[k-1];
        end
    end

    // hash: OR of each selected code at its slot; code 4 spills into the next slot
    always_comb
    begin
        hash = '0;
        for (int b = 0; b < MAX_SEED; b++)
        begin
            if (sel_mask[b])
                hash = hash | (HASH_BITS'(code_next[b]) << shift_amt[b]);
        end
    end

    assign first_idx = IDX_W'(seed_len - LEN_W'(1));
    assign hit       = !bases.is_last && (pos_reg >= 32'(seed_len)) && !isn_next[first_idx];
    assign pos_next  = bases.is_last ? 32'd0 : pos_reg + 32'd1;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < MAX_SEED; k++)
            begin
                code_reg[k] <= code_next[k];
                isn_reg[k]  <= isn_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= 32'd0;
        else if (accept)
            pos_reg <= pos_next;
    end

    assign push           = accept;
    assign push_win.hit   = hit;
    assign push_win.start = hit ? (pos_reg - 32'(seed_len) + 32'd1) : 32'd0;
    assign push_hash      = hit ? hash : '0;

endmodule

FILE: rtl/core/sskic_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sskic_queue
// Small FIFO that decouples the hashing front from the table back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sskic_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sskic_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    `SSKIC_ASSERT_IMP(a_no_overflow, push, cnt_reg != CNT_W'(DEPTH), "queue push while full")
    `SSKIC_ASSERT_IMP(a_no_underflow, pop, cnt_reg != '0, "queue pop while empty")

endmodule

FILE: rtl/core/sskic_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sskic_back
// Occurrence table read-modify-write with forwarding, totals, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sskic_back #(
    parameter int HASH_BITS = sskic_pkg::HASH_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  sskic_pkg::sskic_win_t q_win,
    input  logic [HASH_BITS-1:0]  q_hash,
    output logic                  pop,
    output logic                  clearing,
    sskic_out_if.source           results
);
    import sskic_pkg::*;

    localparam int TABLE_DEPTH = 1 << HASH_BITS;

    logic [7:0]           table_mem [TABLE_DEPTH];

    logic                 clr_reg;
    logic [HASH_BITS-1:0] clr_addr_reg;

    logic                 b_valid_reg;
    sskic_win_t           b_win_reg;
    logic [HASH_BITS-1:0] b_hash_reg;
    logic [7:0]           rd_reg;

    logic                 fwd_valid_reg;
    logic [HASH_BITS-1:0] fwd_addr_reg;
    logic [7:0]           fwd_data_reg;

    logic [31:0]          valid_tot_reg, valid_tot_next;
    logic [31:0]          dist_tot_reg,  dist_tot_next;

    logic                 out_valid_reg;
    logic [31:0]          out_start_reg;
    logic [15:0]          out_hash_reg;
    logic                 out_hit_reg;
    logic                 out_stored_reg;
    logic                 out_first_reg;

    logic                 load;
    logic                 advance;
    logic [7:0]           cnt;
    logic [7:0]           new_cnt;
    logic                 below_cap;
    logic                 item_we;
    logic                 mem_we;
    logic [HASH_BITS-1:0] mem_waddr;
    logic [7:0]           mem_wdata;

    assign advance = b_valid_reg && (!out_valid_reg || results.ready);
    assign load    = q_valid && !clr_reg && (!b_valid_reg || advance);
    assign pop     = load;

    // a write at the edge that loaded this item is not in rd_reg yet
    assign cnt       = (fwd_valid_reg && (fwd_addr_reg == b_hash_reg)) ? fwd_data_reg : rd_reg;
    assign below_cap = (cnt < CAP_LIMIT);
    assign new_cnt   = below_cap ? cnt + 8'd1 : CAP_PARKED;
    assign item_we   = advance && b_win_reg.hit && (cnt <= CAP_LIMIT);

    always_comb
    begin
        valid_tot_next = valid_tot_reg;
        dist_tot_next  = dist_tot_reg;
        if (b_win_reg.hit)
        begin
            if (below_cap)
            begin
                valid_tot_next = valid_tot_reg + 32'd1;
                if (cnt == 8'd0)
                    dist_tot_next = dist_tot_reg + 32'd1;
            end
            else if (cnt == CAP_LIMIT)
            begin
                // hash just became over-represented: drop its recorded windows
                valid_tot_next = valid_tot_reg - 32'(CAP_LIMIT);
            end
        end
    end

    assign mem_we    = clr_reg || item_we;
    assign mem_waddr = clr_reg ? clr_addr_reg : b_hash_reg;
    assign mem_wdata = clr_reg ? 8'd0 : new_cnt;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_waddr] <= mem_wdata;
        if (load)
            rd_reg <= table_mem[q_hash];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b_win_reg    <= q_win;
            b_hash_reg   <= q_hash;
            fwd_addr_reg <= b_hash_reg;
            fwd_data_reg <= new_cnt;
        end
        if (advance)
        begin
            out_start_reg  <= b_win_reg.start;
            out_hash_reg   <= 16'(b_hash_reg);
            out_hit_reg    <= b_win_reg.hit;
            out_stored_reg <= b_win_reg.hit && below_cap;
            out_first_reg  <= b_win_reg.hit && (cnt == 8'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= 1'b1;
            clr_addr_reg  <= '0;
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            valid_tot_reg <= 32'd0;
            dist_tot_reg  <= 32'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + HASH_BITS'(1);
                if (clr_addr_reg == '1)
                    clr_reg <= 1'b0;
            end
            if (load)
                fwd_valid_reg <= item_we;
            if (load)
                b_valid_reg <= 1'b1;
            else if (advance)
                b_valid_reg <= 1'b0;
            if (advance)
            begin
                valid_tot_reg <= valid_tot_next;
                dist_tot_reg  <= dist_tot_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign clearing               = clr_reg;
    assign results.valid          = out_valid_reg;
    assign results.window_start   = out_start_reg;
    assign results.kmer_hash      = out_hash_reg;
    assign results.hash_valid     = out_hit_reg;
    assign results.hash_stored    = out_stored_reg;
    assign results.first_seen     = out_first_reg;
    assign results.valid_total    = valid_tot_reg;
    assign results.distinct_total = dist_tot_reg;

    `SSKIC_ASSERT_IMP(a_first_is_stored, out_valid_reg && out_first_reg, out_stored_reg, "first_seen without store")
    `SSKIC_ASSERT_IMP(a_idle_while_clear, clr_reg, !b_valid_reg && !load, "table access during clear")
    `SSKIC_ASSERT_NXT(a_load_fills_stage, load, b_valid_reg, "loaded item lost")

endmodule

FILE: rtl/core/spaced_seed_kmer_index_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spaced_seed_kmer_index_counter
// Spaced-seed k-mer hasher with a capped per-hash occurrence table.
// ----------------------------------------------------------------------------
//  Channel   Kind          Carries
//  bases     valid/ready   base_char, is_last (one character per item)
//  results   valid/ready   window_start, kmer_hash, flags, running totals
//  apb       APB write/rd  seed_pattern @0x0, seed_length @0x4
//
//  One item per cycle sustained while results are taken; with the pipe empty a result
//  moves through queue slot, table read, then table update into result register.
//  The occurrence table takes one read and one write per cycle; a one-entry
//  forward covers back-to-back hits on the same hash.
//  After reset all 2^HASH_BITS table entries (65536 by default) are cleared, and
//  the bases channel holds ready low meanwhile and in the cycle after any register
//  write. A stalled results side backs up through the 4-entry queue.
// ----------------------------------------------------------------------------
module spaced_seed_kmer_index_counter #(
    parameter int HASH_BITS = sskic_pkg::HASH_BITS_DEF,
    parameter int MAX_SEED  = sskic_pkg::MAX_SEED_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sskic_in_if.sink                      bases,
    sskic_out_if.source                   results,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sskic_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import sskic_pkg::*;

    localparam int LEN_W = $clog2(MAX_SEED + 1);
    localparam int SH_W  = $clog2(2 * MAX_SEED);
    localparam int Q_W   = $bits(sskic_win_t) + HASH_BITS;

    logic [MAX_SEED-1:0]           sel_mask;
    logic [MAX_SEED-1:0][SH_W-1:0] shift_amt;
    logic [LEN_W-1:0]              seed_len;
    logic                          settling;
    logic                          clearing;
    logic                          q_full;
    logic                          q_valid;
    logic                          push;
    logic                          pop;
    sskic_win_t                    push_win;
    logic [HASH_BITS-1:0]          push_hash;
    logic [Q_W-1:0]                q_head;
    sskic_win_t                    head_win;
    logic [HASH_BITS-1:0]          head_hash;

    sskic_cfg #(
        .MAX_SEED (MAX_SEED),
        .LEN_W    (LEN_W),
        .SH_W     (SH_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .sel_mask  (sel_mask),
        .shift_amt (shift_amt),
        .seed_len  (seed_len),
        .settling  (settling)
    );

    sskic_front #(
        .HASH_BITS (HASH_BITS),
        .MAX_SEED  (MAX_SEED),
        .LEN_W     (LEN_W),
        .SH_W      (SH_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .bases     (bases),
        .sel_mask  (sel_mask),
        .shift_amt (shift_amt),
        .seed_len  (seed_len),
        .settling  (settling),
        .clearing  (clearing),
        .q_full    (q_full),
        .push      (push),
        .push_win  (push_win),
        .push_hash (push_hash)
    );

    sskic_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_win, push_hash}),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_head),
        .not_empty (q_valid)
    );

    assign head_win  = q_head[Q_W-1:HASH_BITS];
    assign head_hash = q_head[HASH_BITS-1:0];

    sskic_back #(
        .HASH_BITS (HASH_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_win    (head_win),
        .q_hash   (head_hash),
        .pop      (pop),
        .clearing (clearing),
        .results  (results)
    );

endmodule
